// ===== hdl/assert_macros.svh =====
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/kcg_pkg.sv =====
// shared types and constants of the koch curve segment generator
package kcg_pkg;

   localparam int COORD_W       = 24;
   localparam int LEVEL_W       = 2;
   localparam int DEF_MAX_DEPTH = 3;
   localparam int DIV_CHUNK     = 8;
   localparam int SIN60_Q16     = 56754;
   localparam int COS60_SHIFT   = 15;
   localparam int ROT_FRAC      = 16;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] seg_start_x;
      logic signed [COORD_W-1:0] seg_start_y;
      logic signed [COORD_W-1:0] seg_end_x;
      logic signed [COORD_W-1:0] seg_end_y;
      logic                      last;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [LEVEL_W-1:0]        level;
   } stk_entry_type;

   typedef struct packed {
      logic init;
      logic push;
      logic pop;
   } stk_ctrl_type;

   typedef struct packed {
      logic empty;
      logic one_left;
   } stk_stat_type;

endpackage

// ===== hdl/kcg_div3.sv =====
// iterative unsigned divide by three, one chunk of bits per cycle
module kcg_div3 #(
   parameter int WIDTH = kcg_pkg::COORD_W + 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [1:0]       remainder
);
   import kcg_pkg::*;

   localparam int CH   = DIV_CHUNK;
   localparam int NCH  = (WIDTH + CH - 1) / CH;
   localparam int PADW = NCH * CH;
   localparam int K    = CH + 3;
   localparam int PW   = CH + 2 + K;
   localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;
   localparam logic [K-1:0] RECIP = K'(((1 << K) + 2) / 3);

   logic [PADW-1:0] work_ff;
   logic [PADW-1:0] quo_ff;
   logic [1:0]      rem_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;

   logic [CH+1:0]   digit_w;
   logic [PW-1:0]   digit_prod;
   logic [CH-1:0]   digit_q;
   logic [CH+1:0]   three_q;
   logic [CH+1:0]   digit_diff;

   // reciprocal multiply is exact for a partial dividend below three times the chunk range
   always_comb begin
      digit_w    = {rem_ff, work_ff[PADW-1 -: CH]};
      digit_prod = digit_w * RECIP;
      digit_q    = digit_prod[K +: CH];
      three_q    = {digit_q, 1'b0} + (CH+2)'(digit_q);
      digit_diff = digit_w - three_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            work_ff <= PADW'(dividend);
            rem_ff  <= 2'd0;
            cnt_ff  <= CNTW'(NCH - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            work_ff <= work_ff << CH;
            quo_ff  <= (quo_ff << CH) | PADW'(digit_q);
            rem_ff  <= digit_diff[1:0];
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - CNTW'(1);
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff[WIDTH-1:0];
   assign remainder = rem_ff;

endmodule

// ===== hdl/kcg_stack.sv =====
// register stack of pending segment end points
module kcg_stack #(
   parameter int DEPTH = 1 + 3 * kcg_pkg::DEF_MAX_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kcg_pkg::stk_ctrl_type  ctrl,
   input  kcg_pkg::stk_entry_type wr_entry,
   output kcg_pkg::stk_entry_type top_entry,
   output kcg_pkg::stk_stat_type  stat
);
   import kcg_pkg::*;

   localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   stk_entry_type   mem_ff [DEPTH];
   logic [CNTW-1:0] cnt_ff;
   logic [CNTW-1:0] cnt_dec;

   assign cnt_dec = cnt_ff - CNTW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctrl.init) begin
         mem_ff[0] <= wr_entry;
         cnt_ff    <= CNTW'(1);
      end else if (ctrl.push) begin
         // a push onto a full stack is dropped
         if (cnt_ff < CNTW'(DEPTH)) begin
            mem_ff[cnt_ff[IDXW-1:0]] <= wr_entry;
            cnt_ff                   <= cnt_ff + CNTW'(1);
         end
      end else if (ctrl.pop) begin
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_dec;
         end
      end
   end

   assign top_entry     = mem_ff[cnt_dec[IDXW-1:0]];
   assign stat.empty    = (cnt_ff == '0);
   assign stat.one_left = (cnt_ff == CNTW'(1));

endmodule

// ===== hdl/koch_curve_segment_generator_top.sv =====
// koch curve segment generator, top level with sequencer and shared multiplier
//
// req channel: one word per input segment (start and end point, signed q16.8).
// rsp channel: 4^depth leaf segments per input word, depth-first, last marks
//   the final leaf of that input.
// csr channel: writes the 2-bit subdivision depth (reset value 3), capped at
//   MAX_DEPTH; always ready, write only while the block is idle.
// req_ready is high only while no segment is in progress; an input word is
// taken in the idle state, and at depth 0 its first leaf is then registered
// out of the pop state. each subdivision runs the divide-by-three unit, where
// NCH = ceil((COORD_W + 2) / DIV_CHUNK) is the chunk count of the unit, once
// for x and once for y, followed by two passes through the one multiplier and
// four stack pushes.
// a stalled receiver holds the rsp output register and the sequencer waits
// on the next leaf; subdivision work continues until then.
// reset (synchronous, active high) empties the stack, drops any pending leaf,
// returns to idle and sets depth to 3.
module koch_curve_segment_generator_top #(
   parameter int MAX_DEPTH = kcg_pkg::DEF_MAX_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kcg_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kcg_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_data
);
   import kcg_pkg::*;

`include "assert_macros.svh"

   localparam int CW          = COORD_W;
   localparam int STACK_DEPTH = 1 + 3 * MAX_DEPTH;
   localparam int DIVW        = CW + 2;
   localparam int WW          = CW + 5;
   localparam int RW          = CW + 20;

   localparam logic signed [WW-1:0]   SAT_HI   = WW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [WW-1:0]   SAT_LO   = WW'(-(64'sd1 <<< (CW - 1)));
   localparam logic signed [CW+2:0]   DIV_BIAS = (CW+3)'(64'sd3 <<< CW);
   localparam logic signed [WW-1:0]   Q_BIAS   = WW'(64'sd1 <<< CW);
   localparam logic signed [17:0]     SIN_S    = 18'(SIN60_Q16);
   localparam logic [LEVEL_W-1:0]     LIM_CAP  = LEVEL_W'(MAX_DEPTH);
   localparam logic [1:0]             REM_TWO  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_DIVX,
      ST_DIVY,
      ST_MUL0,
      ST_MUL1,
      ST_APEX,
      ST_PUSH
   } state_type;

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [WW-1:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[CW-1:0];
      end
      if (v < SAT_LO) begin
         return SAT_LO[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   // bias the signed difference by a multiple of three so the divider sees it unsigned
   function automatic logic [DIVW-1:0] to_dividend(input logic signed [CW:0] d);
      logic signed [CW+2:0] t;
      t = (CW+3)'(d) + DIV_BIAS;
      return t[DIVW-1:0];
   endfunction

   // sequencer and datapath registers
   state_type            state_ff, state_in;
   logic [1:0]           depth_ff, depth_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_data_ff, rsp_data_in;
   logic signed [CW-1:0] cur_x_ff, cur_x_in;
   logic signed [CW-1:0] cur_y_ff, cur_y_in;
   logic signed [CW-1:0] px_ff, px_in;
   logic signed [CW-1:0] py_ff, py_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic signed [CW-1:0] cpx_ff, cpx_in;
   logic signed [CW-1:0] cpy_ff, cpy_in;
   logic signed [CW-1:0] dpx_ff, dpx_in;
   logic signed [CW-1:0] dpy_ff, dpy_in;
   logic signed [CW-1:0] ex_ff, ex_in;
   logic signed [CW-1:0] ey_ff, ey_in;
   logic signed [CW+18:0] prod_ry_ff, prod_ry_in;
   logic signed [CW+18:0] prod_rx_ff, prod_rx_in;
   logic [1:0]           push_cnt_ff, push_cnt_in;

   // stack and divider hookup
   stk_ctrl_type         stk_ctrl;
   stk_entry_type        stk_wr;
   stk_entry_type        stk_top;
   stk_stat_type         stk_stat;
   logic                 div_start;
   logic [DIVW-1:0]      div_operand;
   logic                 div_done;
   logic [DIVW-1:0]      div_quo;
   logic [1:0]           div_rem;

   // combinational helpers
   logic [LEVEL_W-1:0]   lim;
   logic                 is_leaf;
   logic                 out_free;
   logic                 emit;
   logic signed [CW:0]   diff_x;
   logic signed [CW:0]   diff_y;
   logic signed [WW-1:0] q_s;
   logic signed [WW-1:0] cur_w;
   logic signed [WW-1:0] round_w;
   logic signed [WW-1:0] near_w;
   logic signed [WW-1:0] far_w;
   logic signed [CW:0]   rx;
   logic signed [CW:0]   ry;
   logic signed [CW:0]   mul_op;
   logic signed [CW+18:0] mul_res;
   logic signed [RW-1:0] ex_sum;
   logic signed [RW-1:0] ey_sum;
   logic signed [WW-1:0] ex_w;
   logic signed [WW-1:0] ey_w;

   kcg_stack #(
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stk_ctrl),
      .wr_entry  (stk_wr),
      .top_entry (stk_top),
      .stat      (stk_stat)
   );

   kcg_div3 #(
      .WIDTH(DIVW)
   ) u_div3 (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_operand),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // arithmetic around the shared units
   always_comb begin
      lim      = (depth_ff > LIM_CAP) ? LIM_CAP : depth_ff;
      is_leaf  = (stk_top.level >= lim);
      out_free = !rsp_valid_ff || rsp_ready;
      emit     = (state_ff == ST_POP) && !stk_stat.empty && is_leaf && out_free;

      diff_x      = (CW+1)'(stk_top.x) - (CW+1)'(cur_x_ff);
      diff_y      = (CW+1)'(py_ff) - (CW+1)'(cur_y_ff);
      div_operand = (state_ff == ST_POP) ? to_dividend(diff_x) : to_dividend(diff_y);

      // one third and two thirds of the span, both floored
      q_s     = $signed({3'b000, div_quo}) - Q_BIAS;
      cur_w   = (state_ff == ST_DIVX) ? WW'(cur_x_ff) : WW'(cur_y_ff);
      round_w = (div_rem == REM_TWO) ? WW'(1) : '0;
      near_w  = cur_w + q_s;
      far_w   = cur_w + (q_s <<< 1) + round_w;

      // apex: rotate d about c by +60 degrees, cos as a shift, sin through the multiplier
      rx      = (CW+1)'(dpx_ff) - (CW+1)'(cpx_ff);
      ry      = (CW+1)'(dpy_ff) - (CW+1)'(cpy_ff);
      mul_op  = (state_ff == ST_MUL0) ? ry : rx;
      mul_res = mul_op * SIN_S;
      ex_sum  = (RW'(rx) <<< COS60_SHIFT) - RW'(prod_ry_ff);
      ey_sum  = (RW'(ry) <<< COS60_SHIFT) + RW'(prod_rx_ff);
      ex_w    = WW'(cpx_ff) + WW'($signed(ex_sum[RW-1:ROT_FRAC]));
      ey_w    = WW'(cpy_ff) + WW'($signed(ey_sum[RW-1:ROT_FRAC]));
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      lvl_in       = lvl_ff;
      cpx_in       = cpx_ff;
      cpy_in       = cpy_ff;
      dpx_in       = dpx_ff;
      dpy_in       = dpy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      prod_ry_in   = prod_ry_ff;
      prod_rx_in   = prod_rx_ff;
      push_cnt_in  = push_cnt_ff;
      stk_ctrl     = '0;
      stk_wr       = '0;
      div_start    = 1'b0;

      if (csr_valid && csr_ready) begin
         depth_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_x_in      = req_data.start_x;
               cur_y_in      = req_data.start_y;
               stk_ctrl.init = 1'b1;
               stk_wr.x      = req_data.end_x;
               stk_wr.y      = req_data.end_y;
               stk_wr.level  = '0;
               state_in      = ST_POP;
            end
         end
         ST_POP: begin
            if (stk_stat.empty) begin
               state_in = ST_IDLE;
            end else if (is_leaf) begin
               if (out_free) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.seg_start_x  = cur_x_ff;
                  rsp_data_in.seg_start_y  = cur_y_ff;
                  rsp_data_in.seg_end_x    = stk_top.x;
                  rsp_data_in.seg_end_y    = stk_top.y;
                  rsp_data_in.last         = stk_stat.one_left;
                  cur_x_in                 = stk_top.x;
                  cur_y_in                 = stk_top.y;
                  stk_ctrl.pop             = 1'b1;
                  state_in = stk_stat.one_left ? ST_IDLE : ST_POP;
               end
            end else begin
               px_in        = stk_top.x;
               py_in        = stk_top.y;
               lvl_in       = stk_top.level;
               stk_ctrl.pop = 1'b1;
               div_start    = 1'b1;
               state_in     = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               cpx_in    = sat_coord(near_w);
               dpx_in    = sat_coord(far_w);
               div_start = 1'b1;
               state_in  = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               cpy_in   = sat_coord(near_w);
               dpy_in   = sat_coord(far_w);
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            prod_ry_in = mul_res;
            state_in   = ST_MUL1;
         end
         ST_MUL1: begin
            prod_rx_in = mul_res;
            state_in   = ST_APEX;
         end
         ST_APEX: begin
            ex_in       = sat_coord(ex_w);
            ey_in       = sat_coord(ey_w);
            push_cnt_in = '0;
            state_in    = ST_PUSH;
         end
         ST_PUSH: begin
            // pushed end first so the first third comes off the stack next
            stk_ctrl.push = 1'b1;
            stk_wr.level  = lvl_ff + LEVEL_W'(1);
            case (push_cnt_ff)
               2'd0: begin
                  stk_wr.x = px_ff;
                  stk_wr.y = py_ff;
               end
               2'd1: begin
                  stk_wr.x = dpx_ff;
                  stk_wr.y = dpy_ff;
               end
               2'd2: begin
                  stk_wr.x = ex_ff;
                  stk_wr.y = ey_ff;
               end
               default: begin
                  stk_wr.x = cpx_ff;
                  stk_wr.y = cpy_ff;
               end
            endcase
            push_cnt_in = push_cnt_ff + 2'd1;
            if (push_cnt_ff == 2'd3) begin
               state_in = ST_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= 2'd3;
         rsp_valid_ff <= 1'b0;
         push_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         push_cnt_ff  <= push_cnt_in;
      end
      rsp_data_ff <= rsp_data_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      lvl_ff      <= lvl_in;
      cpx_ff      <= cpx_in;
      cpy_ff      <= cpy_in;
      dpx_ff      <= dpx_in;
      dpy_ff      <= dpy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      prod_ry_ff  <= prod_ry_in;
      prod_rx_ff  <= prod_rx_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the sequencer never pops an empty stack
   `ASSERT_IMPLY(a_pop_nonempty, clock, reset, stk_ctrl.pop, !stk_stat.empty)
   // an accepted word leaves exactly its end point on the stack
   `ASSERT_NEXT(a_init_one, clock, reset, req_valid && req_ready, stk_stat.one_left)
   // divider results only arrive while the sequencer waits for them
   `ASSERT_IMPLY(a_div_wait, clock, reset, div_done, state_ff == ST_DIVX || state_ff == ST_DIVY)
   // the final leaf is shown marked and the block returns to idle
   `ASSERT_NEXT(a_last_idle, clock, reset, emit && stk_stat.one_left,
      state_ff == ST_IDLE && rsp_valid && rsp_data.last)

endmodule

// ===== tb/sv/kcg_tb_pkg.sv =====
// leaf segment predictor and scoreboard for the koch curve segment generator
`timescale 1ns / 100ps

package kcg_tb_pkg;

   import kcg_pkg::COORD_W;
   import kcg_pkg::req_word_type;
   import kcg_pkg::rsp_word_type;

   localparam int     STACK_SLOTS   = 10;
   localparam int     SHOWN_FAULTS  = 10;
   localparam longint COORD_HI      = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint COORD_LO      = -COORD_HI - 1;
   localparam longint COS60_FRAC    = 32768;
   localparam longint SIN60_FRAC    = 56754;
   localparam int     ROT_SHIFT     = 16;

   class koch_leaf_tracker;
      int unsigned  depth_cap;
      int unsigned  depth_setting;
      rsp_word_type leaf_q[$];
      int           fault_count;

      function new(int unsigned cap);
         depth_cap     = cap;
         depth_setting = 3;
         fault_count   = 0;
      endfunction

      function void set_depth(logic [1:0] d);
         depth_setting = 32'(d);
      endfunction

      function int leaves_outstanding();
         return leaf_q.size();
      endfunction

      static function longint clamp_coord(longint v);
         if (v > COORD_HI) return COORD_HI;
         if (v < COORD_LO) return COORD_LO;
         return v;
      endfunction

      // integer divide by three, rounded toward minus infinity
      static function longint floor_third(longint v);
         longint q;
         q = v / 3;
         if ((v % 3) != 0 && v < 0) q = q - 1;
         return q;
      endfunction

      static function string show(rsp_word_type w);
         return $sformatf("(%0d,%0d)-(%0d,%0d) last=%0b", w.seg_start_x, w.seg_start_y,
                          w.seg_end_x, w.seg_end_y, w.last);
      endfunction

      // expand one accepted segment into its leaves, depth first
      function void take_segment(req_word_type w);
         longint       px [STACK_SLOTS];
         longint       py [STACK_SLOTS];
         int unsigned  plvl [STACK_SLOTS];
         longint       nx [4];
         longint       ny [4];
         int           fill;
         int unsigned  lim;
         int unsigned  lvl;
         longint       ax, ay, bx, by, ddx, ddy, cx, cy, dx, dy, rx, ry, ex, ey;
         rsp_word_type leaf;

         lim     = (depth_setting > depth_cap) ? depth_cap : depth_setting;
         ax      = longint'(w.start_x);
         ay      = longint'(w.start_y);
         px[0]   = longint'(w.end_x);
         py[0]   = longint'(w.end_y);
         plvl[0] = 0;
         fill    = 1;
         while (fill > 0) begin
            fill = fill - 1;
            bx   = px[fill];
            by   = py[fill];
            lvl  = plvl[fill];
            if (lvl >= lim) begin
               leaf.seg_start_x = ax[COORD_W-1:0];
               leaf.seg_start_y = ay[COORD_W-1:0];
               leaf.seg_end_x   = bx[COORD_W-1:0];
               leaf.seg_end_y   = by[COORD_W-1:0];
               leaf.last        = (fill == 0);
               leaf_q.push_back(leaf);
               ax = bx;
               ay = by;
            end else begin
               ddx = bx - ax;
               ddy = by - ay;
               cx  = clamp_coord(ax + floor_third(ddx));
               cy  = clamp_coord(ay + floor_third(ddy));
               dx  = clamp_coord(ax + floor_third(2 * ddx));
               dy  = clamp_coord(ay + floor_third(2 * ddy));
               rx  = dx - cx;
               ry  = dy - cy;
               ex  = clamp_coord(cx + ((rx * COS60_FRAC - ry * SIN60_FRAC) >>> ROT_SHIFT));
               ey  = clamp_coord(cy + ((rx * SIN60_FRAC + ry * COS60_FRAC) >>> ROT_SHIFT));
               // pushed far end first so a-c comes off the stack next
               nx = '{bx, dx, ex, cx};
               ny = '{by, dy, ey, cy};
               for (int k = 0; k < 4; k++) begin
                  if (fill < STACK_SLOTS) begin
                     px[fill]   = nx[k];
                     py[fill]   = ny[k];
                     plvl[fill] = lvl + 1;
                     fill       = fill + 1;
                  end
               end
            end
         end
      endfunction

      function void note_fault(string msg);
         fault_count++;
         if (fault_count <= SHOWN_FAULTS) $display("%s", msg);
      endfunction

      function void check_leaf(rsp_word_type got);
         rsp_word_type want;
         if (leaf_q.size() == 0) begin
            note_fault({"unexpected leaf: ", show(got)});
            return;
         end
         want = leaf_q.pop_front();
         if (got.seg_start_x !== want.seg_start_x || got.seg_start_y !== want.seg_start_y ||
             got.seg_end_x !== want.seg_end_x || got.seg_end_y !== want.seg_end_y ||
             got.last !== want.last)
            note_fault({"leaf mismatch: expected ", show(want), " got ", show(got)});
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_koch_curve_segment_generator_top.sv =====
// top level testbench of the koch curve segment generator
`timescale 1ns / 100ps

module tb_koch_curve_segment_generator_top;

   import kcg_pkg::req_word_type;
   import kcg_pkg::rsp_word_type;
   import kcg_tb_pkg::*;

   // cycles with no accepted word before the run is declared hung
   localparam int QUIET_LIMIT   = 3000;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 60;
   localparam int SETTLE_CYCLES = 32;

   bit                  clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_word_type        req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_word_type        rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_data;

   koch_leaf_tracker    leaf_board;
   bit                  req_gaps_on;
   bit                  rsp_stalls_on;
   int                  stall_left;
   int                  quiet_cycles;

   koch_curve_segment_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 8 ns clock, first rising edge at 4 ns
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: ready drops in random bursts while stalls are enabled
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_ready  = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // leaf checking and hang watchdog, both on the sampling edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) leaf_board.check_leaf(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("koch_curve_segment_generator_top regression: fail");
               $finish;
            end
         end
      end
   end

   function automatic req_word_type make_segment(longint sx, longint sy, longint ex,
                                                 longint ey);
      req_word_type w;
      w.start_x = sx[kcg_pkg::COORD_W-1:0];
      w.start_y = sy[kcg_pkg::COORD_W-1:0];
      w.end_x   = ex[kcg_pkg::COORD_W-1:0];
      w.end_y   = ey[kcg_pkg::COORD_W-1:0];
      return w;
   endfunction

   function automatic longint rand_coord();
      return COORD_LO + longint'($urandom_range(0, 24'hFF_FFFF));
   endfunction

   // corner values show up often so saturation of the apex gets exercised
   function automatic longint pick_coord();
      case ($urandom_range(0, 4))
         0: return COORD_LO;
         1: return COORD_HI;
         2: return 0;
         3: return -1;
         default: return rand_coord();
      endcase
   endfunction

   function automatic req_word_type random_segment();
      longint sx;
      longint sy;
      case ($urandom_range(0, 3))
         2: begin
            // short segment, small deltas stress the floor rounding
            sx = rand_coord();
            sy = rand_coord();
            return make_segment(sx, sy,
               koch_leaf_tracker::clamp_coord(sx + longint'($urandom_range(0, 8191)) - 4096),
               koch_leaf_tracker::clamp_coord(sy + longint'($urandom_range(0, 8191)) - 4096));
         end
         3: return make_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord());
         default: return make_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      endcase
   endfunction

   // entered and left at a falling edge; valid stays up after acceptance so a
   // following word can go out back to back
   task automatic send_segment(req_word_type w);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (!req_ready);
      leaf_board.take_segment(w);
      @(negedge clock);
   endtask

   task automatic write_depth(logic [1:0] d);
      csr_valid = 1'b1;
      csr_data  = d;
      do @(posedge clock); while (!csr_ready);
      leaf_board.set_depth(d);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // every segment gives at least one leaf, so an empty queue plus an open
   // input channel means the sequencer is back to idle
   task automatic drain_block();
      req_valid = 1'b0;
      while (leaf_board.leaves_outstanding() != 0) @(negedge clock);
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin
      req_word_type corner_q[$];
      int unsigned  depth_plan [RANDOM_PHASES];

      depth_plan    = '{2, 0, 3, 1, 3, 2, 0, 3};
      leaf_board    = new(kcg_pkg::DEF_MAX_DEPTH);
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      stall_left    = 0;
      quiet_cycles  = 0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;

      // the first four cover the full diagonal span and both apex overflows
      corner_q.push_back(make_segment(COORD_LO, COORD_LO, COORD_HI, COORD_HI));
      corner_q.push_back(make_segment(COORD_LO, COORD_HI, COORD_HI, COORD_HI));
      corner_q.push_back(make_segment(COORD_HI, COORD_LO, COORD_LO, COORD_LO));
      corner_q.push_back(make_segment(COORD_HI, COORD_HI, COORD_HI, COORD_LO));
      corner_q.push_back(make_segment(0, 0, 0, 0));
      corner_q.push_back(make_segment(COORD_HI, COORD_HI, COORD_LO, COORD_LO));
      corner_q.push_back(make_segment(COORD_HI, COORD_LO, COORD_HI, COORD_HI));
      corner_q.push_back(make_segment(COORD_LO, COORD_HI, COORD_LO, COORD_LO));
      // small deltas, mostly negative, most of them not multiples of three
      corner_q.push_back(make_segment(-1, -1, -2, -5));
      corner_q.push_back(make_segment(5, 7, -3, -11));
      corner_q.push_back(make_segment(-1, -1, 0, 0));
      // degenerate segment away from the origin
      corner_q.push_back(make_segment(17, -4, 17, -4));

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // directed words at the reset depth, then a few at each lower depth
      foreach (corner_q[k]) send_segment(corner_q[k]);
      for (int d = 0; d < 3; d++) begin
         drain_block();
         write_depth(2'(d));
         for (int k = 0; k < 4; k++) send_segment(corner_q[k]);
      end

      // random phases, depth changed only with the block idle; the final
      // phase runs at full rate on both sides
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_block();
         write_depth(2'(depth_plan[p]));
         if (p == RANDOM_PHASES - 1) begin
            req_gaps_on   = 1'b0;
            rsp_stalls_on = 1'b0;
         end else begin
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         repeat (PHASE_ITEMS) send_segment(random_segment());
      end

      drain_block();
      // let any stray leaf show up before the verdict
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (leaf_board.fault_count == 0 && leaf_board.leaves_outstanding() == 0)
         $display("koch_curve_segment_generator_top regression: pass");
      else
         $display("koch_curve_segment_generator_top regression: fail");
      $finish;
   end

endmodule
